@@ rtl/bpa_pkg.sv @@
// Shared types and codes for the buddy page allocator.
package bpa_pkg;

  typedef logic [47:0] addr_t;
  typedef logic [16:0] cnt_t;
  typedef logic [4:0]  ord_t;
  typedef logic [1:0]  kind_t;

  localparam kind_t KIND_ALLOC = 2'd0;
  localparam kind_t KIND_FREE  = 2'd1;
  localparam kind_t KIND_SEED  = 2'd2;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 64;

  localparam logic [1:0] REG_BASE   = 2'd0;
  localparam logic [1:0] REG_TOTAL  = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

endpackage

@@ rtl/bpa_req_if.sv @@
// Request channel: kind, block order and physical address.
interface bpa_req_if import bpa_pkg::*; ();
  logic  valid;
  logic  ready;
  kind_t kind;
  ord_t  block_order;
  addr_t phys_address;

  modport source(output valid, kind, block_order, phys_address, input ready);
  modport sink(input valid, kind, block_order, phys_address, output ready);
endinterface

@@ rtl/bpa_rsp_if.sv @@
// Result channel: address, accept flag and free page count.
interface bpa_rsp_if import bpa_pkg::*; ();
  logic  valid;
  logic  ready;
  addr_t result_address;
  logic  accepted;
  cnt_t  pages_free;

  modport source(output valid, result_address, accepted, pages_free, input ready);
  modport sink(input valid, result_address, accepted, pages_free, output ready);
endinterface

@@ rtl/buddy_page_allocator_core.sv @@
// Buddy page allocator: request/result channels, APB registers, list and bitmap sequencer.
//
// Requests arrive on req (valid/ready); each produces one transfer on rsp.
// Registers: base_address at 0x00, page_total at 0x08, enabled at 0x10 (64-bit APB).
// After reset a clearing pass over all MAX_PAGES pages marks every page used and
// unlisted; req.ready stays low until it finishes. Register writes are taken
// at any time.
// One request is worked at a time by a sequencer around a page bitmap RAM and
// link/tag RAMs:
//   alloc: scan orders, unlink, then per split a push; then mark the pages
//   free : check the address, mark the pages, then per merge scan and unlink
//          the buddy; a last buddy check, then a push. Seed skips the merges
//          and that check.
// The result sits in an output register; the next request is taken while it
// waits, and the sequencer holds at its end only if the previous result has
// not yet been transferred.
module buddy_page_allocator_core import bpa_pkg::*; #(
  parameter int TOP_ORDER  = 10,
  parameter int MAX_PAGES  = 65536,
  parameter int PAGE_SHIFT = 12
) (
  input  logic               clk,
  input  logic               rst,
  bpa_req_if.sink            req,
  bpa_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  localparam int PW = $clog2(MAX_PAGES);
  localparam int LW = PW + 1;
  localparam int OW = $clog2(TOP_ORDER + 1);
  localparam int IW = TOP_ORDER + 1;
  localparam int M1 = (PW > TOP_ORDER) ? PW : TOP_ORDER;
  localparam int CW = ((M1 > 17) ? M1 : 17) + 2;
  localparam logic [LW-1:0] NO_LINK = LW'(1) << PW;
  localparam logic [CW-1:0] PAGES_C = CW'(MAX_PAGES);
  localparam ord_t MAXO = 5'(TOP_ORDER);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_SUB, S_CHK, S_SCAN, S_UL_RD, S_UL_WR, S_SPLIT,
    S_PU_RD, S_PU_CHK, S_PU_A, S_PU_B, S_MARK, S_CO, S_CO_TAG, S_CO_SCAN, S_DONE
  } state_t;

  state_t state;
  addr_t base_address;
  cnt_t page_total;
  logic enabled;

  logic [LW-1:0] head [TOP_ORDER+1];
  logic [PW:0] clr;
  kind_t kind;
  ord_t ord, cur, pu_ord;
  addr_t phys, diff;
  logic below;
  logic [CW-1:0] p, bud, pu_page, ul_page;
  logic [IW-1:0] idx;
  logic mark_val, pend, pend_oob;
  cnt_t cnt;
  addr_t res_addr;
  logic res_ok, rsp_valid;
  addr_t rsp_addr;
  logic rsp_ok;
  cnt_t rsp_cnt;

  logic used_we, used_wd, used_rd;
  logic [PW-1:0] used_wa, used_ra;
  logic tag_we;
  logic [PW-1:0] tag_wa;
  logic [5:0] tag_wd, tag_rd;
  logic nxt_we, prv_we;
  logic [PW-1:0] nxt_wa, prv_wa, rd_addr;
  logic [LW-1:0] nxt_wd, prv_wd, nxt_rd, prv_rd;

  logic [CW-1:0] limit, b, m, mk_pg, scan_pg, rd_full, ul_tgt;
  logic align_bad, do_unlink;
  logic [LW-1:0] hd_cur, hd_pu;
  logic [IW-1:0] n_ord, n_cur;
  logic [17:0] n18, sum18;
  addr_t pfull;
  state_t ret_state;

  bpa_ram #(.W(1), .D(MAX_PAGES)) u_used (
    .clk, .we(used_we), .waddr(used_wa), .wdata(used_wd), .raddr(used_ra), .rdata(used_rd)
  );
  bpa_ram #(.W(6), .D(MAX_PAGES)) u_tag (
    .clk, .we(tag_we), .waddr(tag_wa), .wdata(tag_wd), .raddr(rd_addr), .rdata(tag_rd)
  );
  bpa_ram #(.W(LW), .D(MAX_PAGES)) u_nxt (
    .clk, .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd), .raddr(rd_addr), .rdata(nxt_rd)
  );
  bpa_ram #(.W(LW), .D(MAX_PAGES)) u_prv (
    .clk, .we(prv_we), .waddr(prv_wa), .wdata(prv_wd), .raddr(rd_addr), .rdata(prv_rd)
  );

  assign limit = (CW'(page_total) < PAGES_C) ? CW'(page_total) : PAGES_C;
  assign b = p ^ (CW'(1) << cur);
  assign m = (p < b) ? p : b;
  assign align_bad = |(m & ((CW'(1) << (cur + 5'd1)) - CW'(1)));
  assign hd_cur = head[cur[OW-1:0]];
  assign hd_pu = head[pu_ord[OW-1:0]];
  assign n_ord = IW'(1) << ord;
  assign n_cur = IW'(1) << cur;
  assign mk_pg = p + CW'(idx);
  assign scan_pg = bud + CW'(idx);
  assign ul_tgt = (state == S_UL_WR) ? ul_page : pu_page;
  assign do_unlink = (state == S_UL_WR) || (state == S_PU_CHK && tag_rd[5]);
  assign n18 = 18'(1) << ord;
  assign sum18 = {1'b0, cnt} + n18;
  assign pfull = diff >> PAGE_SHIFT;
  assign ret_state = (kind == KIND_ALLOC) ? S_SPLIT : S_DONE;
  assign rd_addr = rd_full[PW-1:0];
  assign used_ra = scan_pg[PW-1:0];

  always_comb begin
    case (state)
      S_UL_RD: rd_full = ul_page;
      S_PU_RD: rd_full = pu_page;
      S_CO:    rd_full = b;
      default: rd_full = '0;
    endcase
  end

  always_comb begin
    used_we = 1'b0;
    used_wa = mk_pg[PW-1:0];
    used_wd = mark_val;
    tag_we = 1'b0;
    tag_wa = ul_tgt[PW-1:0];
    tag_wd = '0;
    nxt_we = 1'b0;
    nxt_wa = prv_rd[PW-1:0];
    nxt_wd = nxt_rd;
    prv_we = 1'b0;
    prv_wa = nxt_rd[PW-1:0];
    prv_wd = prv_rd;
    if (do_unlink) begin
      nxt_we = !prv_rd[PW];
      prv_we = !nxt_rd[PW];
      tag_we = 1'b1;
    end
    case (state)
      S_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr[PW-1:0];
        used_wd = 1'b1;
        tag_we = 1'b1;
        tag_wa = clr[PW-1:0];
      end
      S_PU_A: begin
        prv_we = 1'b1;
        prv_wa = pu_page[PW-1:0];
        prv_wd = NO_LINK;
        nxt_we = 1'b1;
        nxt_wa = pu_page[PW-1:0];
        nxt_wd = hd_pu;
        tag_we = 1'b1;
        tag_wd = {1'b1, pu_ord};
      end
      S_PU_B: begin
        prv_we = !hd_pu[PW];
        prv_wa = hd_pu[PW-1:0];
        prv_wd = pu_page[LW-1:0];
      end
      S_MARK: used_we = (idx < n_ord) && (mk_pg < PAGES_C);
      default: ;
    endcase
  end

  assign pready = 1'b1;
  always_comb begin
    case (paddr[PADDR_W-1:3])
      REG_BASE:   prdata = PDATA_W'(base_address);
      REG_TOTAL:  prdata = PDATA_W'(page_total);
      REG_ENABLE: prdata = PDATA_W'(enabled);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      page_total <= '0;
      enabled <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[PADDR_W-1:3])
        REG_BASE:   base_address <= pwdata[47:0];
        REG_TOTAL:  page_total <= pwdata[16:0];
        REG_ENABLE: enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.result_address = rsp_addr;
  assign rsp.accepted = rsp_ok;
  assign rsp.pages_free = rsp_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      cnt <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i <= TOP_ORDER; i++) head[i] <= NO_LINK;
    end else begin
      if (rsp_valid && rsp.ready && state != S_DONE) rsp_valid <= 1'b0;
      if (do_unlink && prv_rd[PW]) head[tag_rd[OW-1:0]] <= nxt_rd;
      case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == (PW+1)'(MAX_PAGES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            kind <= req.kind;
            ord <= req.block_order;
            cur <= req.block_order;
            phys <= req.phys_address;
            res_addr <= '0;
            res_ok <= 1'b0;
            if (!enabled || req.block_order > MAXO ||
                (req.kind != KIND_ALLOC && req.kind != KIND_FREE &&
                 req.kind != KIND_SEED)) begin
              state <= S_DONE;
            end else if (req.kind == KIND_ALLOC) begin
              state <= S_SCAN;
            end else begin
              state <= S_SUB;
            end
          end
        end
        S_SUB: begin
          diff <= phys - base_address;
          below <= phys < base_address;
          state <= S_CHK;
        end
        S_CHK: begin
          p <= pfull[CW-1:0];
          idx <= '0;
          mark_val <= 1'b0;
          state <= (!below && pfull < 48'(limit)) ? S_MARK : S_DONE;
        end
        S_SCAN: begin
          if (cur > MAXO) begin
            state <= S_DONE;
          end else if (hd_cur[PW]) begin
            cur <= cur + 5'd1;
          end else begin
            p <= CW'(hd_cur);
            ul_page <= CW'(hd_cur);
            state <= S_UL_RD;
          end
        end
        S_UL_RD: state <= S_UL_WR;
        S_UL_WR: begin
          if (kind == KIND_ALLOC) begin
            state <= S_SPLIT;
          end else begin
            p <= (p < bud) ? p : bud;
            cur <= cur + 5'd1;
            state <= S_CO;
          end
        end
        S_SPLIT: begin
          if (cur > ord) begin
            cur <= cur - 5'd1;
            pu_page <= p + (CW'(1) << (cur - 5'd1));
            pu_ord <= cur - 5'd1;
            state <= S_PU_RD;
          end else begin
            idx <= '0;
            mark_val <= 1'b1;
            state <= S_MARK;
          end
        end
        S_PU_RD: state <= (pu_page < PAGES_C) ? S_PU_CHK : ret_state;
        S_PU_CHK: state <= S_PU_A;
        S_PU_A: state <= S_PU_B;
        S_PU_B: begin
          head[pu_ord[OW-1:0]] <= pu_page[LW-1:0];
          state <= ret_state;
        end
        S_MARK: begin
          if (idx < n_ord) begin
            idx <= idx + 1'b1;
          end else begin
            res_ok <= 1'b1;
            if (kind == KIND_ALLOC) begin
              cnt <= ({1'b0, cnt} > n18) ? cnt - n18[16:0] : '0;
              res_addr <= base_address + (48'(p) << PAGE_SHIFT);
              state <= S_DONE;
            end else begin
              cnt <= sum18[17] ? '1 : sum18[16:0];
              cur <= ord;
              if (kind == KIND_SEED) begin
                pu_page <= p;
                pu_ord <= ord;
                state <= S_PU_RD;
              end else begin
                state <= S_CO;
              end
            end
          end
        end
        S_CO: begin
          bud <= b;
          if (cur >= MAXO || b >= limit || align_bad) begin
            pu_page <= p;
            pu_ord <= cur;
            state <= S_PU_RD;
          end else begin
            state <= S_CO_TAG;
          end
        end
        S_CO_TAG: begin
          idx <= '0;
          pend <= 1'b0;
          if (!tag_rd[5] || tag_rd[4:0] != cur) begin
            pu_page <= p;
            pu_ord <= cur;
            state <= S_PU_RD;
          end else begin
            state <= S_CO_SCAN;
          end
        end
        S_CO_SCAN: begin
          if (pend && (pend_oob || used_rd)) begin
            pu_page <= p;
            pu_ord <= cur;
            state <= S_PU_RD;
          end else if (idx == n_cur && !pend) begin
            ul_page <= bud;
            state <= S_UL_RD;
          end else if (idx < n_cur) begin
            idx <= idx + 1'b1;
            pend <= 1'b1;
            pend_oob <= scan_pg >= PAGES_C;
          end else begin
            pend <= 1'b0;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_addr <= res_addr;
            rsp_ok <= res_ok;
            rsp_cnt <= cnt;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready) else $error("request taken during clearing pass");
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.accepted |-> rsp.result_address == '0)
    else $error("rejected request carries an address");
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE) else $error("transfer not started");
`endif
endmodule

@@ rtl/bpa_ram.sv @@
// Generic single write, single read RAM with registered read data.
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the buddy page allocator core: directed table, then random phases.
`timescale 1ns / 100ps

module testbench;
  import bpa_pkg::*;

  localparam int       TOP_ORDER  = 10;
  localparam int       MAX_PAGES  = 65536;
  localparam int       PAGE_SHIFT = 12;
  localparam int       LIMIT      = 20000000;
  localparam int       NUM_OFF    = 2;
  localparam int       PHASE_ITEMS = 105;
  localparam kind_t    KIND_BAD   = 2'd3;
  localparam int unsigned NO_LINK = 32'hFFFF_FFFF;
  localparam addr_t    DIR_BASE   = 48'h0000_8000_0000;

  typedef struct packed {
    addr_t address;
    logic  accepted;
    cnt_t  pages_free;
  } alloc_rsp_t;

  typedef struct {
    kind_t      kind;
    ord_t       ord;
    addr_t      phys;
    bit         typed;
    alloc_rsp_t rsp;
  } dir_row_t;

  typedef struct {
    addr_t addr;
    ord_t  ord;
  } live_blk_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  bpa_req_if req_ch();
  bpa_rsp_if rsp_ch();

  buddy_page_allocator_core #(
    .TOP_ORDER(TOP_ORDER), .MAX_PAGES(MAX_PAGES), .PAGE_SHIFT(PAGE_SHIFT)
  ) u_dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // allocator shadow state
  bit             pg_used_bits [MAX_PAGES];
  int unsigned    nxt_pg [MAX_PAGES];
  int unsigned    prv_pg [MAX_PAGES];
  ord_t           pg_tag [MAX_PAGES];
  bit             pg_listed [MAX_PAGES];
  int unsigned    order_head [TOP_ORDER+1];
  longint unsigned free_pages;
  addr_t          cfg_base;
  logic [16:0]    cfg_total;
  logic           cfg_en;

  alloc_rsp_t rsp_pending_q[$];
  live_blk_t  live_q[$];
  int         err_cnt = 0;
  bit         quiet = 0;
  int         rdy_gap = 0;

  function automatic bit page_busy(longint unsigned p);
    if (p >= MAX_PAGES) return 1;
    return pg_used_bits[p];
  endfunction

  function automatic void mark_pages(longint unsigned p, int o, bit v);
    for (longint unsigned i = 0; i < (64'd1 << o); i++)
      if (p + i < MAX_PAGES) pg_used_bits[p + i] = v;
  endfunction

  function automatic bit span_free(longint unsigned p, int o);
    for (longint unsigned i = 0; i < (64'd1 << o); i++)
      if (page_busy(p + i)) return 0;
    return 1;
  endfunction

  function automatic void shadow_unlink(int unsigned p);
    int unsigned pv, nx;
    pv = prv_pg[p];
    nx = nxt_pg[p];
    if (pv != NO_LINK) nxt_pg[pv] = nx;
    else order_head[pg_tag[p]] = nx;
    if (nx != NO_LINK) prv_pg[nx] = pv;
    pg_listed[p] = 0;
  endfunction

  function automatic void shadow_push(longint unsigned p, int o);
    int unsigned q;
    if (p >= MAX_PAGES) return;
    q = p[31:0];
    if (pg_listed[q]) shadow_unlink(q);
    prv_pg[q] = NO_LINK;
    nxt_pg[q] = order_head[o];
    if (order_head[o] != NO_LINK) prv_pg[order_head[o]] = q;
    order_head[o] = q;
    pg_listed[q] = 1;
    pg_tag[q] = ord_t'(o);
  endfunction

  function automatic alloc_rsp_t predict_alloc(kind_t k, ord_t o, addr_t phys);
    alloc_rsp_t r;
    longint unsigned lim, p, b, m, n;
    int cur;
    int unsigned q;
    r = '0;
    lim = (cfg_total < MAX_PAGES) ? cfg_total : MAX_PAGES;
    if (cfg_en && o <= TOP_ORDER) begin
      if (k == KIND_ALLOC) begin
        cur = o;
        while (cur <= TOP_ORDER && order_head[cur] == NO_LINK) cur++;
        if (cur <= TOP_ORDER) begin
          q = order_head[cur];
          shadow_unlink(q);
          while (cur > o) begin
            cur--;
            shadow_push(longint'(q) + (64'd1 << cur), cur);
          end
          mark_pages(q, o, 1);
          n = 64'd1 << o;
          free_pages = (free_pages > n) ? free_pages - n : 0;
          r.address = cfg_base + (longint'(q) << PAGE_SHIFT);
          r.accepted = 1;
        end
      end else if ((k == KIND_FREE || k == KIND_SEED) && phys >= cfg_base) begin
        p = (phys - cfg_base) >> PAGE_SHIFT;
        if (p < lim) begin
          cur = o;
          mark_pages(p, o, 0);
          free_pages += 64'd1 << o;
          if (free_pages > 64'h1FFFF) free_pages = 64'h1FFFF;
          if (k == KIND_FREE) begin
            while (cur < TOP_ORDER) begin
              b = p ^ (64'd1 << cur);
              m = (p < b) ? p : b;
              if (b >= lim) break;
              if (!span_free(b, cur)) break;
              if ((m & ((64'd1 << (cur + 1)) - 1)) != 0) break;
              if (!pg_listed[b] || pg_tag[b] != cur) break;
              shadow_unlink(b[31:0]);
              p = m;
              cur++;
            end
          end
          shadow_push(p, cur);
          r.accepted = 1;
        end
      end
    end
    r.pages_free = free_pages[16:0];
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random backpressure and checking
  always @(posedge clk) begin
    alloc_rsp_t e;
    if (rst) begin
      rsp_ch.ready <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (rsp_pending_q.size() == 0) begin
          $error("unexpected result transfer");
          err_cnt++;
        end else begin
          e = rsp_pending_q.pop_front();
          if (rsp_ch.result_address !== e.address) begin
            $error("result_address exp %h got %h", e.address, rsp_ch.result_address);
            err_cnt++;
          end
          if (rsp_ch.accepted !== e.accepted) begin
            $error("accepted exp %b got %b", e.accepted, rsp_ch.accepted);
            err_cnt++;
          end
          if (rsp_ch.pages_free !== e.pages_free) begin
            $error("pages_free exp %0d got %0d", e.pages_free, rsp_ch.pages_free);
            err_cnt++;
          end
        end
      end
      if (rdy_gap > 0) begin
        rdy_gap <= rdy_gap - 1;
        rsp_ch.ready <= 0;
      end else begin
        rsp_ch.ready <= 1;
        if (!quiet && $urandom_range(0, 5) == 0)
          rdy_gap <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150) :
                                                     $urandom_range(1, 4);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 150);
  endfunction

  task automatic send_req(kind_t k, ord_t o, addr_t a, bit typed, alloc_rsp_t t);
    int gap;
    alloc_rsp_t e;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.kind <= k;
    req_ch.block_order <= o;
    req_ch.phys_address <= a;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    e = predict_alloc(k, o, a);
    if (k == KIND_ALLOC && e.accepted) live_q.push_back('{e.address, o});
    rsp_pending_q.push_back(typed ? t : e);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    @(posedge clk);
    while (rsp_pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    logic [63:0] exp_rd;
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    case (idx)
      REG_BASE:   begin cfg_base = val[47:0];  exp_rd = {16'd0, val[47:0]}; end
      REG_TOTAL:  begin cfg_total = val[16:0]; exp_rd = {47'd0, val[16:0]}; end
      default:    begin cfg_en = val[0];       exp_rd = {63'd0, val[0]};    end
    endcase
    penable <= 0; pwrite <= 0;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    if (prdata !== exp_rd) begin
      $error("prdata exp %h got %h", exp_rd, prdata);
      err_cnt++;
    end
    psel <= 0; penable <= 0;
    @(posedge clk);
  endtask

  task automatic set_config(addr_t b, logic [16:0] tot, logic en);
    reg_write(REG_BASE, b);
    reg_write(REG_TOTAL, tot);
    reg_write(REG_ENABLE, en);
  endtask

  function automatic ord_t rand_order();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(11, 31);
  endfunction

  task automatic rand_req(bit seed_only);
    int r, idx;
    longint unsigned lim, p;
    ord_t o;
    addr_t a;
    live_blk_t lb;
    lim = (cfg_total < MAX_PAGES) ? cfg_total : MAX_PAGES;
    r = $urandom_range(0, 99);
    if (seed_only) begin
      p = $urandom_range(0, 63) * 1024;
      send_req(KIND_SEED, 5'd10, cfg_base + (p << PAGE_SHIFT), 0, '0);
    end else if (r < 10) begin
      send_req(kind_t'($urandom_range(0, 3)), ord_t'($urandom_range(0, 31)),
               {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, 0, '0);
    end else if (r < 45) begin
      send_req(KIND_ALLOC, rand_order(), {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF, 0, '0);
    end else if (r < 80 && live_q.size() != 0) begin
      idx = $urandom_range(0, live_q.size() - 1);
      lb = live_q[idx];
      if ($urandom_range(0, 9) != 0) live_q.delete(idx);
      o = lb.ord;
      if ($urandom_range(0, 19) == 0) o = $urandom_range(0, TOP_ORDER);
      send_req(KIND_FREE, o, lb.addr, 0, '0);
    end else begin
      o = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 3);
      p = (lim == 0) ? $urandom_range(0, 255) : $urandom_range(0, lim - 1);
      p = p & ~((64'd1 << o) - 1);
      if (lim == MAX_PAGES && $urandom_range(0, 29) == 0) begin
        p = MAX_PAGES - 1;
        o = 10;
      end
      a = cfg_base + (p << PAGE_SHIFT);
      if ($urandom_range(0, 9) == 0) a = a + $urandom_range(1, 4095);
      send_req(($urandom_range(0, 1) == 0) ? KIND_FREE : KIND_SEED, o, a, 0, '0);
    end
  endtask

  dir_row_t dir_tab [] = '{
    '{KIND_ALLOC, 5'd0,  48'd0,                  1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_SEED,  5'd0,  DIR_BASE,               1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_BAD,   5'd0,  DIR_BASE,               1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_ALLOC, 5'd0,  48'd0,                  1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_SEED,  5'd11, DIR_BASE,               1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_SEED,  5'd31, DIR_BASE,               1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_SEED,  5'd0,  DIR_BASE - 48'd1,       1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_SEED,  5'd0,  DIR_BASE + 48'h40000,   1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_FREE,  5'd0,  DIR_BASE + 48'h40000,   1, '{48'd0, 1'b0, 17'd0}},
    '{KIND_SEED,  5'd3,  DIR_BASE + 48'h8000,    1, '{48'd0, 1'b1, 17'd8}},
    '{KIND_FREE,  5'd0,  DIR_BASE + 48'h9000,    0, '0},
    '{KIND_SEED,  5'd3,  DIR_BASE,               0, '0},
    '{KIND_FREE,  5'd3,  DIR_BASE,               0, '0},
    '{KIND_ALLOC, 5'd0,  48'hFFFF_FFFF_FFFF,     0, '0},
    '{KIND_ALLOC, 5'd2,  48'd0,                  0, '0},
    '{KIND_ALLOC, 5'd10, 48'd0,                  0, '0},
    '{KIND_FREE,  5'd0,  DIR_BASE + 48'h123,     0, '0},
    '{KIND_SEED,  5'd10, DIR_BASE,               0, '0},
    '{KIND_SEED,  5'd0,  DIR_BASE + 48'h3F000,   0, '0},
    '{KIND_SEED,  5'd0,  DIR_BASE + 48'h3F000,   0, '0},
    '{KIND_ALLOC, 5'd10, 48'd0,                  0, '0},
    '{KIND_FREE,  5'd10, DIR_BASE,               0, '0},
    '{KIND_FREE,  5'd0,  48'hFFFF_FFFF_FFFF,     0, '0}
  };

  int phase_kind [] = '{0, 1, 2, 5, 3, 4, 0, 0, 1, 0};

  initial begin
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    req_ch.valid = 0; req_ch.kind = KIND_ALLOC; req_ch.block_order = '0;
    req_ch.phys_address = '0;
    for (int i = 0; i < MAX_PAGES; i++) begin
      pg_used_bits[i] = 1;
      pg_listed[i] = 0;
      pg_tag[i] = '0;
      nxt_pg[i] = 0;
      prv_pg[i] = 0;
    end
    for (int i = 0; i <= TOP_ORDER; i++) order_head[i] = NO_LINK;
    free_pages = 0;
    cfg_base = '0; cfg_total = '0; cfg_en = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (i == NUM_OFF) begin
        drain();
        set_config(DIR_BASE, 17'd64, 1'b1);
      end
      send_req(dir_tab[i].kind, dir_tab[i].ord, dir_tab[i].phys,
               dir_tab[i].typed, dir_tab[i].rsp);
    end

    foreach (phase_kind[ph]) begin
      drain();
      live_q.delete();
      quiet = ($urandom_range(0, 3) == 0);
      case (phase_kind[ph])
        0: set_config({$urandom_range(0, 32'hFFFFF), $urandom_range(0, 65535), 12'h000},
                      $urandom_range(16, 300), 1'b1);
        1: set_config(48'd0, 17'd65536, 1'b1);
        2: set_config(48'h0000_1000_0000, 17'h1FFFF, 1'b1);
        3: set_config({$urandom_range(0, 65535), $urandom, 12'h000} & 48'hFFFF_FFFF_FFFF,
                      17'd0, 1'b1);
        4: set_config({$urandom_range(0, 65535), 20'd0, 12'h000}, 17'd100, 1'b0);
        default: set_config(48'hFFFF_FFFF_F000, 17'd16, 1'b1);
      endcase
      if (phase_kind[ph] == 2)
        repeat (130) rand_req(1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && ph == 1) drain();
        rand_req(0);
      end
    end

    drain();
    repeat (200) @(posedge clk);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
